[hdl/hrhs_pkg.sv]
// ----------------------------------------------------------------------------
// hrhs_pkg
// Types, codes and reset constants for the hello retry handshake sender.
// ----------------------------------------------------------------------------
`default_nettype none

package hrhs_pkg;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [7:0]  MAX_ATTEMPTS_RST  = 8'd3;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd20;
    localparam logic [7:0]  ATTEMPT_MAX       = 8'hff;
    localparam logic [15:0] TICK_MAX          = 16'hffff;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_ATTEMPTS  = 1'b0,
        CFG_TIMEOUT_TICKS = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        KIND_CONNECT      = 3'd0,
        KIND_CONNECT_POLL = 3'd1,
        KIND_POLL         = 3'd2,
        KIND_HELLO_SENT   = 3'd3,
        KIND_ACK          = 3'd4,
        KIND_TICK         = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_SEND = 2'd1,
        ACT_DONE = 2'd2,
        ACT_FAIL = 2'd3
    } action_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] generation;
    } in_t;

    typedef struct packed {
        logic [1:0]  action;
        logic        ack_accepted;
        logic        is_running;
        logic        is_waiting;
        logic [31:0] current_generation;
    } out_t;

    typedef struct packed {
        logic        running;
        logic        hello_due;
        logic        waiting;
        logic        armed;
        logic        received;
        logic [7:0]  attempt_count;
        logic [15:0] tick_count;
        logic [31:0] generation;
    } state_t;

    typedef struct packed {
        logic [7:0]  max_attempts;
        logic [15:0] timeout_ticks;
    } cfg_t;

endpackage

`default_nettype wire

[hdl/hrhs_step.sv]
// ----------------------------------------------------------------------------
// hrhs_step
// Next state and result for one event, applied to the current state.
// ----------------------------------------------------------------------------
`default_nettype none

module hrhs_step
    import hrhs_pkg::*;
(
    input  var state_t st,
    input  var cfg_t   cfg,
    input  var in_t    item,
    output var state_t st_next,
    output var out_t   result
);

    state_t     conn;
    state_t     base;
    logic [1:0] action;
    logic       accepted;
    logic [15:0] tick_inc;

    always_comb begin
        conn              = st;
        conn.generation   = item.generation;
        conn.attempt_count = '0;
        conn.tick_count   = '0;
        conn.running      = 1'b1;
        conn.hello_due    = 1'b1;
        conn.waiting      = 1'b0;
        conn.armed        = 1'b0;
        conn.received     = 1'b0;
    end

    assign tick_inc = (st.tick_count != TICK_MAX) ? st.tick_count + 16'd1 : st.tick_count;

    always_comb begin
        base     = st;
        action   = ACT_NONE;
        accepted = 1'b0;
        case (item.kind)
            KIND_CONNECT: begin
                base = conn;
            end
            KIND_CONNECT_POLL: begin
                base              = conn;
                base.hello_due    = 1'b0;
                action            = ACT_SEND;
            end
            KIND_POLL: begin
                if (st.running && st.hello_due) begin
                    base.hello_due    = 1'b0;
                    action            = ACT_SEND;
                end
            end
            KIND_HELLO_SENT: begin
                if (st.running && !st.waiting) begin
                    base.waiting    = 1'b1;
                    base.armed      = 1'b1;
                    base.received   = 1'b0;
                    base.tick_count = '0;
                    if (st.attempt_count != ATTEMPT_MAX) begin
                        base.attempt_count = st.attempt_count + 8'd1;
                    end
                end
            end
            KIND_ACK: begin
                if (st.running && st.waiting && st.armed) begin
                    base.received = 1'b1;
                    accepted      = 1'b1;
                end
            end
            KIND_TICK: begin
                if (st.running && st.waiting) begin
                    if (st.received) begin
                        base.waiting      = 1'b0;
                        base.armed        = 1'b0;
                        base.received     = 1'b0;
                        base.running      = 1'b0;
                        base.hello_due    = 1'b0;
                        action            = ACT_DONE;
                    end else if (tick_inc < cfg.timeout_ticks) begin
                        base.tick_count = tick_inc;
                    end else begin
                        base.waiting      = 1'b0;
                        base.armed        = 1'b0;
                        base.received     = 1'b0;
                        base.hello_due    = 1'b1;
                        base.tick_count   = '0;
                        if (st.attempt_count >= cfg.max_attempts) begin
                            base.attempt_count = '0;
                            action             = ACT_FAIL;
                        end else begin
                            action = ACT_SEND;
                        end
                    end
                end
            end
            default: begin
                base = st;
            end
        endcase
    end

    assign st_next = base;

    always_comb begin
        result.action             = action;
        result.ack_accepted       = accepted;
        result.is_running         = base.running;
        result.is_waiting         = base.waiting;
        result.current_generation = base.generation;
    end

endmodule

`default_nettype wire

[hdl/hello_retry_handshake_fsm.sv]
// each accepted event's result is registered in the output register
// throughput: one event per cycle unless m_ready stalls; state update and result are
// a single combinational pass between the state registers and the output register
// reset: synchronous active-low aresetn clears all flags, counters, generation
// and the output valid, and loads max_attempts 3 and timeout_ticks 20
// ----------------------------------------------------------------------------
// hello_retry_handshake_fsm
// Hello handshake sender with acknowledgement timeout and bounded retries.
// ----------------------------------------------------------------------------
`default_nettype none

module hello_retry_handshake_fsm
    import hrhs_pkg::*;
(
    input  var logic                  aclk,
    input  var logic                  aresetn,
    input  var logic                  cfg_we,
    input  var logic [CFG_IDX_W-1:0]  cfg_index,
    input  var logic [CFG_DATA_W-1:0] cfg_wdata,
    input  var logic                  s_valid,
    output var logic                  s_ready,
    input  var in_t                   s_data,
    output var logic                  m_valid,
    input  var logic                  m_ready,
    output var out_t                  m_data
);

    cfg_t   cfg_reg;
    state_t state_reg;
    state_t state_next;
    out_t   result;
    out_t   out_reg;
    logic   m_valid_reg;
    logic   accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    hrhs_step u_step (
        .st      (state_reg),
        .cfg     (cfg_reg),
        .item    (s_data),
        .st_next (state_next),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_attempts  <= MAX_ATTEMPTS_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_TICKS_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MAX_ATTEMPTS:  cfg_reg.max_attempts  <= cfg_wdata[7:0];
                CFG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= cfg_wdata[15:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                state_reg <= state_next;
            end
            if (s_ready) begin
                m_valid_reg <= s_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= result;
        end
    end

endmodule

`default_nettype wire

[hdl/hrhs_checker.sv]
// ----------------------------------------------------------------------------
// hrhs_checker
// Port-level checks for the hello retry handshake sender, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module hrhs_checker
    import hrhs_pkg::*;
(
    input var logic aclk,
    input var logic aresetn,
    input var logic s_valid,
    input var logic s_ready,
    input var logic m_valid,
    input var logic m_ready,
    input var out_t m_data
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // an accepted event always produces a result next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted event produced no result");

    // empty output stage never blocks input
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output stage");

    // completion ends the session
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.action == ACT_DONE |-> !m_data.is_running && !m_data.is_waiting)
        else $error("complete while still running");

    // an accepted ack only happens while waiting and yields no action
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.ack_accepted
            |-> m_data.is_running && m_data.is_waiting && m_data.action == ACT_NONE)
        else $error("ack accepted outside waiting state");

endmodule

bind hello_retry_handshake_fsm hrhs_checker u_hrhs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

[tb/sv/tb_hello_retry_handshake_fsm.sv]
// ----------------------------------------------------------------------------
// tb_hello_retry_handshake_fsm
// Self-checking bench for the hello retry handshake sender. A directed table
// walks the reset state, unused kinds and one full handshake. Randomized
// connect / hello / ack / tick sessions follow under several retry and timeout
// settings, including zero and full-scale values. Every result is compared
// with an in-bench model of the sender, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_hello_retry_handshake_fsm
    import hrhs_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] KIND_UNUSED_6 = 3'd6;
    localparam logic [2:0] KIND_UNUSED_7 = 3'd7;
    localparam int unsigned HOLD_CYCLES  = 60;
    localparam int unsigned PHASE_ITEMS  = 100;
    localparam int unsigned NUM_PHASES   = 7;
    localparam int unsigned DIR_ROWS     = 24;

    typedef struct {
        in_t  ev;
        bit   typed;
        out_t want;
    } stim_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    cfg_idx_t              cfg_index = CFG_MAX_ATTEMPTS;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_t                   s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_t                  m_data;

    state_t hs;
    cfg_t   hcfg;
    out_t   predicted_outcomes [$];
    stim_t  stim_q [$];
    stim_t  directed_tab [DIR_ROWS];
    out_t   head;

    int unsigned snd_idle = 0;
    int unsigned rcv_idle = 0;
    int unsigned hold_reqs = 0;
    int unsigned mismatches = 0;
    int unsigned events_sent = 0;
    int unsigned results_checked = 0;
    int unsigned n_send = 0, n_done = 0, n_fail = 0, n_acks = 0;

    int unsigned ph_max  [NUM_PHASES] = '{3, 1, 0, 255, 2, 5, 8};
    int unsigned ph_tmo  [NUM_PHASES] = '{5, 1, 0, 65535, 3, 2, 12};
    int unsigned ph_sidl [NUM_PHASES] = '{32, 32, 77, 77, 0, 0, 0};
    int unsigned ph_ridl [NUM_PHASES] = '{77, 77, 32, 32, 0, 0, 0};
    bit          ph_hold [NUM_PHASES] = '{0, 1, 0, 1, 1, 0, 0};
    bit          ph_pause[NUM_PHASES] = '{1, 0, 0, 0, 1, 0, 0};

    hello_retry_handshake_fsm dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("FAIL hello_retry_handshake_fsm");
        $finish;
    end

    // sender model: next state and result for one event
    function automatic out_t sender_step(in_t ev);
        out_t    r;
        action_t act;
        logic    acc;
        act = ACT_NONE;
        acc = 1'b0;
        case (ev.kind)
            KIND_CONNECT, KIND_CONNECT_POLL: begin
                hs.generation    = ev.generation;
                hs.attempt_count = '0;
                hs.tick_count    = '0;
                hs.running       = 1'b1;
                hs.hello_due     = 1'b1;
                hs.waiting       = 1'b0;
                hs.armed         = 1'b0;
                hs.received      = 1'b0;
                if (ev.kind == KIND_CONNECT_POLL) begin
                    hs.hello_due = 1'b0;
                    act = ACT_SEND;
                end
            end
            KIND_POLL: begin
                if (hs.running && hs.hello_due) begin
                    hs.hello_due = 1'b0;
                    act = ACT_SEND;
                end
            end
            KIND_HELLO_SENT: begin
                if (hs.running && !hs.waiting) begin
                    hs.waiting    = 1'b1;
                    hs.armed      = 1'b1;
                    hs.received   = 1'b0;
                    hs.tick_count = '0;
                    if (hs.attempt_count != ATTEMPT_MAX)
                        hs.attempt_count = hs.attempt_count + 8'd1;
                end
            end
            KIND_ACK: begin
                if (hs.running && hs.waiting && hs.armed) begin
                    hs.received = 1'b1;
                    acc = 1'b1;
                end
            end
            KIND_TICK: begin
                if (hs.running && hs.waiting) begin
                    if (hs.received) begin
                        hs.waiting      = 1'b0;
                        hs.armed        = 1'b0;
                        hs.received     = 1'b0;
                        hs.running      = 1'b0;
                        hs.hello_due    = 1'b0;
                        act = ACT_DONE;
                    end else begin
                        if (hs.tick_count != TICK_MAX)
                            hs.tick_count = hs.tick_count + 16'd1;
                        if (hs.tick_count >= hcfg.timeout_ticks) begin
                            hs.waiting      = 1'b0;
                            hs.armed        = 1'b0;
                            hs.received     = 1'b0;
                            hs.hello_due    = 1'b1;
                            hs.tick_count   = '0;
                            if (hs.attempt_count >= hcfg.max_attempts) begin
                                hs.attempt_count = '0;
                                act = ACT_FAIL;
                            end else begin
                                act = ACT_SEND;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        r.action             = act;
        r.ack_accepted       = acc;
        r.is_running         = hs.running;
        r.is_waiting         = hs.waiting;
        r.current_generation = hs.generation;
        return r;
    endfunction

    function automatic bit same_result(out_t got, out_t want);
        return got.action === want.action && got.ack_accepted === want.ack_accepted
            && got.is_running === want.is_running && got.is_waiting === want.is_waiting
            && got.current_generation === want.current_generation;
    endfunction

    task automatic send_item(stim_t st);
        out_t pred;
        @(negedge aclk);
        while ($urandom_range(99) < snd_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= st.ev;
        do @(posedge aclk); while (!s_ready);
        pred = sender_step(st.ev);
        predicted_outcomes.push_back(st.typed ? st.want : pred);
        events_sent++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (predicted_outcomes.size() != 0) @(posedge aclk);
    endtask

    task automatic cfg_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        if (idx == CFG_MAX_ATTEMPTS)
            hcfg.max_attempts = data[7:0];
        else
            hcfg.timeout_ticks = data;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_event(logic [2:0] k, logic [31:0] g);
        stim_t st;
        st.typed = 1'b0;
        st.want  = '0;
        // stray transaction of any kind
        if ($urandom_range(99) < 6) begin
            st.ev.kind       = 3'($urandom_range(7));
            st.ev.generation = $urandom;
            stim_q.push_back(st);
        end
        st.ev.kind       = k;
        st.ev.generation = g;
        stim_q.push_back(st);
    endtask

    task automatic build_sessions(int unsigned n_items);
        int unsigned rounds, nt, r, i;
        while (stim_q.size() < n_items) begin
            if ($urandom_range(1)) begin
                queue_event(KIND_CONNECT_POLL, $urandom);
            end else begin
                queue_event(KIND_CONNECT, $urandom);
                queue_event(KIND_POLL, $urandom);
            end
            rounds = $urandom_range(1, (hcfg.max_attempts > 5) ? 6 : hcfg.max_attempts + 2);
            for (r = 0; r < rounds; r++) begin
                queue_event(KIND_HELLO_SENT, $urandom);
                if ($urandom_range(9) < 3) begin
                    nt = $urandom_range(2);
                    for (i = 0; i < nt; i++) queue_event(KIND_TICK, $urandom);
                    queue_event(KIND_ACK, $urandom);
                    if ($urandom_range(3) == 0) queue_event(KIND_ACK, $urandom);
                    queue_event(KIND_TICK, $urandom);
                    break;
                end
                if (hcfg.timeout_ticks > 24)
                    nt = $urandom_range(1, 6);
                else
                    nt = (hcfg.timeout_ticks == 0) ? 1 : hcfg.timeout_ticks;
                for (i = 0; i < nt; i++) queue_event(KIND_TICK, $urandom);
                queue_event(KIND_POLL, $urandom);
            end
        end
    endtask

    // receiver side, with occasional long hold-off
    initial begin
        int unsigned served, hold_left;
        served    = 0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_left == 0 && served != hold_reqs) begin
                served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= rcv_idle);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (predicted_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with no transaction pending: %h", m_data);
            end else begin
                head = predicted_outcomes.pop_front();
                if (!same_result(m_data, head)) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch at result %0d: act %0d/%0d ack %b/%b ",
                                  "run %b/%b wait %b/%b gen %h/%h"},
                                 results_checked, m_data.action, head.action,
                                 m_data.ack_accepted, head.ack_accepted,
                                 m_data.is_running, head.is_running,
                                 m_data.is_waiting, head.is_waiting,
                                 m_data.current_generation, head.current_generation);
                end
            end
            case (m_data.action)
                ACT_SEND: n_send++;
                ACT_DONE: n_done++;
                ACT_FAIL: n_fail++;
                default: ;
            endcase
            if (m_data.ack_accepted) n_acks++;
        end
    end

    initial begin
        int unsigned ph, k, n;
        hs   = '0;
        hcfg = '{MAX_ATTEMPTS_RST, TIMEOUT_TICKS_RST};
        directed_tab = '{
            '{in_t'{KIND_POLL,       32'h0},        1'b1, out_t'{ACT_NONE, 1'b0, 1'b0, 1'b0, 32'h0}},
            '{in_t'{KIND_TICK,       32'hffffffff}, 1'b1, out_t'{ACT_NONE, 1'b0, 1'b0, 1'b0, 32'h0}},
            '{in_t'{KIND_ACK,        32'h0},        1'b1, out_t'{ACT_NONE, 1'b0, 1'b0, 1'b0, 32'h0}},
            '{in_t'{KIND_HELLO_SENT, 32'hffffffff}, 1'b1, out_t'{ACT_NONE, 1'b0, 1'b0, 1'b0, 32'h0}},
            '{in_t'{KIND_UNUSED_6,   32'hffffffff}, 1'b1, out_t'{ACT_NONE, 1'b0, 1'b0, 1'b0, 32'h0}},
            '{in_t'{KIND_UNUSED_7,   32'h0},        1'b1, out_t'{ACT_NONE, 1'b0, 1'b0, 1'b0, 32'h0}},
            '{in_t'{KIND_CONNECT,    32'hffffffff}, 1'b1,
              out_t'{ACT_NONE, 1'b0, 1'b1, 1'b0, 32'hffffffff}},
            '{in_t'{KIND_ACK,        32'h0},        1'b0, out_t'('0)},
            '{in_t'{KIND_POLL,       32'h0},        1'b0, out_t'('0)},
            '{in_t'{KIND_POLL,       32'h0},        1'b0, out_t'('0)},
            '{in_t'{KIND_HELLO_SENT, 32'h0},        1'b0, out_t'('0)},
            '{in_t'{KIND_HELLO_SENT, 32'h0},        1'b0, out_t'('0)},
            '{in_t'{KIND_ACK,        32'hffffffff}, 1'b0, out_t'('0)},
            '{in_t'{KIND_ACK,        32'h0},        1'b0, out_t'('0)},
            '{in_t'{KIND_TICK,       32'h0},        1'b0, out_t'('0)},
            '{in_t'{KIND_TICK,       32'h0},        1'b0, out_t'('0)},
            '{in_t'{KIND_CONNECT_POLL, 32'h0},      1'b1, out_t'{ACT_SEND, 1'b0, 1'b1, 1'b0, 32'h0}},
            '{in_t'{KIND_POLL,       32'h0},        1'b0, out_t'('0)},
            '{in_t'{KIND_HELLO_SENT, 32'ha5a5a5a5}, 1'b0, out_t'('0)},
            '{in_t'{KIND_UNUSED_6,   32'h5a5a5a5a}, 1'b0, out_t'('0)},
            '{in_t'{KIND_TICK,       32'h0},        1'b0, out_t'('0)},
            '{in_t'{KIND_CONNECT,    32'h12345678}, 1'b0, out_t'('0)},
            '{in_t'{KIND_TICK,       32'h0},        1'b0, out_t'('0)},
            '{in_t'{KIND_CONNECT_POLL, 32'h80000001}, 1'b0, out_t'('0)}
        };
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_tab[i]) send_item(directed_tab[i]);

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            repeat (3) @(posedge aclk);
            cfg_write(CFG_MAX_ATTEMPTS, {8'($urandom), 8'(ph_max[ph])});
            cfg_write(CFG_TIMEOUT_TICKS, 16'(ph_tmo[ph]));
            snd_idle = ph_sidl[ph];
            rcv_idle = ph_ridl[ph];
            build_sessions(PHASE_ITEMS);
            n = stim_q.size();
            k = 0;
            while (stim_q.size() != 0) begin
                if (k == n / 2) begin
                    if (ph_hold[ph]) hold_reqs++;
                    if (ph_pause[ph]) wait_drained();
                end
                send_item(stim_q.pop_front());
                k++;
            end
        end

        wait_drained();
        repeat (4) @(posedge aclk);
        $display({"%0d transactions over %0d settings (retries 0..255, ",
                  "timeout 0..65535), %0d checked"},
                 events_sent, NUM_PHASES + 1, results_checked);
        $display("saw %0d hello requests, %0d completions, %0d failures, %0d acks accepted",
                 n_send, n_done, n_fail, n_acks);
        if (mismatches == 0) begin
            $display("PASS hello_retry_handshake_fsm");
        end else begin
            $display("FAIL hello_retry_handshake_fsm");
        end
        $finish;
    end

endmodule
